/* sv/tllru_pkg.sv */
`default_nettype none
package tllru_pkg;

   // fixed field widths
   localparam int DIV_W      = 13;
   localparam int STAMP_W    = 32;
   localparam int CFG_IDX_W  = 2;
   localparam int CFG_DATA_W = 13;
   localparam int L1E_W      = 9;
   localparam int WAYS_W     = 4;
   localparam int BSIZE_W    = 13;
   localparam int OUT_W      = 2;

   // register reset values
   localparam logic [L1E_W-1:0]   L1E_RESET   = 9'd256;
   localparam logic [WAYS_W-1:0]  WAYS_RESET  = 4'd4;
   localparam logic [BSIZE_W-1:0] BSIZE_RESET = 13'd64;

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_L1_ENTRIES = 2'd0,
      CFG_WAYS       = 2'd1,
      CFG_BLK_BYTES  = 2'd2
   } cfg_idx_type;

   typedef enum logic [OUT_W-1:0] {
      OUT_L1_HIT = 2'd0,
      OUT_L2_HIT = 2'd1,
      OUT_MISS   = 2'd2
   } outcome_type;

   typedef enum logic [1:0] {
      DIV_SETS  = 2'd0,
      DIV_BLOCK = 2'd1,
      DIV_SET   = 2'd2
   } div_op_type;

   typedef enum logic {
      LVL_1 = 1'b0,
      LVL_2 = 1'b1
   } level_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_W_SETS, S_W_BLOCK, S_GO_SET, S_W_SET, S_BASE,
      S_L1_RD, S_L1_CMP, S_L2_INIT, S_L2_RD, S_L2_CMP, S_FILL2, S_FILL1, S_RESP
   } state_type;

   typedef struct packed {
      logic        clr_step;
      logic        load;
      logic        div_go;
      div_op_type  div_op;
      logic        scan_init;
      logic        rd;
      logic        cmp;
      logic        wr;
      logic        wr_victim;
      level_type   lvl;
      logic        out_set;
      outcome_type out_code;
      logic        rsp_push;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic div_done;
      logic hit;
      logic last_way;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

/* sv/tllru_dpath.sv */
`default_nettype none
module tllru_dpath import tllru_pkg::*; #(
   parameter int MAX_L1_ENTRIES = 256,
   parameter int MAX_WAYS       = 8,
   parameter int ADDR_BITS      = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic                  csr_we,
   input  wire logic [CFG_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_DATA_W-1:0] csr_wdata,
   input  wire logic [ADDR_BITS-1:0]  req_address,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output logic [OUT_W-1:0]           rsp_outcome
);

   localparam int L1_DEPTH = MAX_L1_ENTRIES;
   localparam int L2_DEPTH = 2 * MAX_L1_ENTRIES;
   localparam int L1A      = (MAX_L1_ENTRIES > 1) ? $clog2(MAX_L1_ENTRIES) : 1;
   localparam int L2A      = $clog2(L2_DEPTH);
   localparam int WW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int DVW      = (ADDR_BITS > DIV_W) ? ADDR_BITS : DIV_W;
   localparam int CW       = $clog2(DVW + 1);
   localparam int EW       = 1 + ADDR_BITS + STAMP_W;

   // configuration registers
   logic [L1E_W-1:0]   l1e_ff;
   logic [WAYS_W-1:0]  ways_ff;
   logic [BSIZE_W-1:0] bsize_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1e_ff   <= L1E_RESET;
         ways_ff  <= WAYS_RESET;
         bsize_ff <= BSIZE_RESET;
      end else if (csr_we) begin
         unique case (cfg_idx_type'(csr_index))
            CFG_L1_ENTRIES: l1e_ff   <= csr_wdata[L1E_W-1:0];
            CFG_WAYS:       ways_ff  <= csr_wdata[WAYS_W-1:0];
            CFG_BLK_BYTES:  bsize_ff <= csr_wdata[BSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // effective geometry after clamping
   logic [DIV_W-1:0] ent_eff, nw_eff, bs_eff;

   always_comb begin
      ent_eff = DIV_W'(l1e_ff);
      if (ent_eff == '0) ent_eff = DIV_W'(1);
      if (ent_eff > DIV_W'(MAX_L1_ENTRIES)) ent_eff = DIV_W'(MAX_L1_ENTRIES);
      nw_eff = DIV_W'(ways_ff);
      if (nw_eff == '0) nw_eff = DIV_W'(1);
      if (nw_eff > DIV_W'(MAX_WAYS)) nw_eff = DIV_W'(MAX_WAYS);
      if (nw_eff > ent_eff) nw_eff = ent_eff;
      bs_eff = (bsize_ff == '0) ? DIV_W'(1) : DIV_W'(bsize_ff);
   end

   // item registers and access clock
   logic [ADDR_BITS-1:0] addr_ff;
   logic [STAMP_W-1:0]   clock_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff <= '0;
      end else if (cmd.load) begin
         clock_ff <= clock_ff + STAMP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) addr_ff <= req_address;
   end

   // division results: set count, block number, L1 set and tag
   logic [DIV_W-1:0]     sets1_ff, set1_ff, set2_ff;
   logic [ADDR_BITS-1:0] block_ff, tag1_ff, tag2;

   // shared restoring divider, one quotient bit per cycle
   logic [DVW-1:0]   dvd;
   logic [DIV_W-1:0] dvs;
   logic [DVW-1:0]   q_ff, q_in;
   logic [DIV_W-1:0] rem_ff, rem_in, dvs_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   div_op_type       op_ff;
   logic [DIV_W:0]   trial;
   logic             div_done;

   always_comb begin
      case (cmd.div_op)
         DIV_SETS:  begin dvd = DVW'(ent_eff);              dvs = nw_eff;   end
         DIV_BLOCK: begin dvd = DVW'(addr_ff - ADDR_BITS'(1)); dvs = bs_eff; end
         default:   begin dvd = DVW'(block_ff);             dvs = sets1_ff; end
      endcase
   end

   always_comb begin
      trial = {rem_ff, q_ff[DVW-1]};
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = DIV_W'(trial - {1'b0, dvs_ff});
         q_in   = {q_ff[DVW-2:0], 1'b1};
      end else begin
         rem_in = trial[DIV_W-1:0];
         q_in   = {q_ff[DVW-2:0], 1'b0};
      end
   end

   assign div_done = busy_ff && (cnt_ff == CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.div_go) begin
         busy_ff <= 1'b1;
      end else if (div_done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_go) begin
         q_ff   <= dvd;
         rem_ff <= '0;
         dvs_ff <= dvs;
         cnt_ff <= CW'(DVW);
         op_ff  <= cmd.div_op;
      end else if (busy_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (div_done) begin
         case (op_ff)
            DIV_SETS:  sets1_ff <= q_in[DIV_W-1:0];
            DIV_BLOCK: block_ff <= q_in[ADDR_BITS-1:0];
            default: begin
               set1_ff <= rem_in;
               tag1_ff <= q_in[ADDR_BITS-1:0];
               // L2 has twice the sets: the low quotient bit picks the upper half
               set2_ff <= q_in[0] ? rem_in + sets1_ff : rem_in;
            end
         endcase
      end
   end

   assign tag2 = tag1_ff >> 1;

   // set base entries
   logic [2*DIV_W-1:0] prod1, prod2;
   logic [L1A-1:0]     base1_ff;
   logic [L2A-1:0]     base2_ff;

   assign prod1 = set1_ff * nw_eff;
   assign prod2 = set2_ff * nw_eff;

   always_ff @(posedge clock) begin
      base1_ff <= prod1[L1A-1:0];
      base2_ff <= prod2[L2A-1:0];
   end

   // way scan with hit check and victim tracking per level
   logic [WW-1:0]      way_ff;
   logic [EW-1:0]      rd1_ff, rd2_ff, cur;
   logic [L1A-1:0]     idx1_ff, vic1;
   logic [L2A-1:0]     idx2_ff, vic2;
   logic [1:0]         inv_found_ff;
   logic [WW-1:0]      inv_w_ff [2];
   logic [WW-1:0]      min_w_ff [2];
   logic [STAMP_W-1:0] min_st_ff [2];
   logic [WW-1:0]      vw1, vw2;
   logic               cur_valid;
   logic [ADDR_BITS-1:0] cur_tag, cmp_tag;
   logic [STAMP_W-1:0] cur_st;
   logic               lv;

   assign lv        = (cmd.lvl == LVL_2);
   assign cur       = lv ? rd2_ff : rd1_ff;
   assign cur_valid = cur[EW-1];
   assign cur_tag   = cur[EW-2:STAMP_W];
   assign cur_st    = cur[STAMP_W-1:0];
   assign cmp_tag   = lv ? tag2 : tag1_ff;

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         way_ff           <= '0;
         inv_found_ff[lv] <= 1'b0;
      end else if (cmd.cmp) begin
         way_ff <= way_ff + WW'(1);
         if (!cur_valid && !inv_found_ff[lv]) begin
            inv_found_ff[lv] <= 1'b1;
            inv_w_ff[lv]     <= way_ff;
         end
         if (way_ff == '0 || cur_st < min_st_ff[lv]) begin
            min_st_ff[lv] <= cur_st;
            min_w_ff[lv]  <= way_ff;
         end
      end
   end

   assign vw1  = inv_found_ff[0] ? inv_w_ff[0] : min_w_ff[0];
   assign vw2  = inv_found_ff[1] ? inv_w_ff[1] : min_w_ff[1];
   assign vic1 = base1_ff + L1A'(vw1);
   assign vic2 = base2_ff + L2A'(vw2);

   // L1 and L2 entry memories: {valid, tag, stamp}
   logic [EW-1:0]  l1_mem [L1_DEPTH];
   logic [EW-1:0]  l2_mem [L2_DEPTH];
   logic [L2A-1:0] clr_cnt_ff;
   logic [EW-1:0]  wdata;
   logic           we1, we2;
   logic [L1A-1:0] wa1;
   logic [L2A-1:0] wa2;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= clr_cnt_ff + L2A'(1);
      end
   end

   always_comb begin
      wdata = cmd.clr_step ? '0 : {1'b1, (lv ? tag2 : tag1_ff), clock_ff};
      we1   = (cmd.clr_step && (32'(clr_cnt_ff) < L1_DEPTH)) ||
              (cmd.wr && !lv);
      we2   = cmd.clr_step || (cmd.wr && lv);
      wa1   = cmd.clr_step ? clr_cnt_ff[L1A-1:0] : (cmd.wr_victim ? vic1 : idx1_ff);
      wa2   = cmd.clr_step ? clr_cnt_ff : (cmd.wr_victim ? vic2 : idx2_ff);
   end

   always_ff @(posedge clock) begin
      if (we1) l1_mem[wa1] <= wdata;
      if (cmd.rd && !lv) begin
         rd1_ff  <= l1_mem[base1_ff + L1A'(way_ff)];
         idx1_ff <= base1_ff + L1A'(way_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (we2) l2_mem[wa2] <= wdata;
      if (cmd.rd && lv) begin
         rd2_ff  <= l2_mem[base2_ff + L2A'(way_ff)];
         idx2_ff <= base2_ff + L2A'(way_ff);
      end
   end

   // result register
   logic                rsp_valid_ff;
   outcome_type         out_ff, rsp_out_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_set) out_ff <= cmd.out_code;
      if (cmd.rsp_push) rsp_out_ff <= out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_outcome = rsp_out_ff;

   always_comb begin
      status.clr_done = (clr_cnt_ff == L2A'(L2_DEPTH - 1));
      status.div_done = div_done;
      status.hit      = cur_valid && (cur_tag == cmp_tag);
      status.last_way = (DIV_W'(way_ff) == nw_eff - DIV_W'(1));
      status.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

`ifndef SYNTH
   // a new result never overwrites one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_push |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten");

   // each accepted item advances the access clock by one
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> clock_ff == $past(clock_ff) + STAMP_W'(1))
      else $error("access clock did not advance");
`endif

endmodule
`default_nettype wire

/* sv/tllru_ctrl.sv */
`default_nettype none
module tllru_ctrl import tllru_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:   if (status.clr_done) state_in = S_IDLE;
         S_IDLE:    if (req_valid) state_in = S_W_SETS;
         S_W_SETS:  if (status.div_done) state_in = S_W_BLOCK;
         S_W_BLOCK: if (status.div_done) state_in = S_GO_SET;
         S_GO_SET:  state_in = S_W_SET;
         S_W_SET:   if (status.div_done) state_in = S_BASE;
         S_BASE:    state_in = S_L1_RD;
         S_L1_RD:   state_in = S_L1_CMP;
         S_L1_CMP: begin
            if (status.hit)           state_in = S_RESP;
            else if (status.last_way) state_in = S_L2_INIT;
            else                      state_in = S_L1_RD;
         end
         S_L2_INIT: state_in = S_L2_RD;
         S_L2_RD:   state_in = S_L2_CMP;
         S_L2_CMP: begin
            if (status.hit)           state_in = S_FILL1;
            else if (status.last_way) state_in = S_FILL2;
            else                      state_in = S_L2_RD;
         end
         S_FILL2:   state_in = S_FILL1;
         S_FILL1:   state_in = S_RESP;
         S_RESP:    if (status.rsp_free) state_in = S_IDLE;
         default:   state_in = S_CLEAR;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      cmd.lvl   = LVL_1;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_CLEAR: cmd.clr_step = 1'b1;
         S_IDLE: begin
            cmd.load   = req_valid;
            cmd.div_go = req_valid;
            cmd.div_op = DIV_SETS;
         end
         S_W_SETS: begin
            cmd.div_go = status.div_done;
            cmd.div_op = DIV_BLOCK;
         end
         S_GO_SET: begin
            cmd.div_go = 1'b1;
            cmd.div_op = DIV_SET;
         end
         S_BASE: cmd.scan_init = 1'b1;
         S_L1_RD: cmd.rd = 1'b1;
         S_L1_CMP: begin
            cmd.cmp      = 1'b1;
            cmd.wr       = status.hit;
            cmd.out_set  = status.hit;
            cmd.out_code = OUT_L1_HIT;
         end
         // restart the way scan for L2
         S_L2_INIT: begin
            cmd.scan_init = 1'b1;
            cmd.lvl       = LVL_2;
         end
         S_L2_RD: begin
            cmd.rd  = 1'b1;
            cmd.lvl = LVL_2;
         end
         S_L2_CMP: begin
            cmd.cmp      = 1'b1;
            cmd.lvl      = LVL_2;
            cmd.wr       = status.hit;
            cmd.out_set  = status.hit || status.last_way;
            cmd.out_code = status.hit ? OUT_L2_HIT : OUT_MISS;
         end
         S_FILL2: begin
            cmd.wr        = 1'b1;
            cmd.wr_victim = 1'b1;
            cmd.lvl       = LVL_2;
         end
         S_FILL1: begin
            cmd.wr        = 1'b1;
            cmd.wr_victim = 1'b1;
         end
         S_RESP: cmd.rsp_push = status.rsp_free;
         default: ;
      endcase
   end

`ifndef SYNTH
   // divider completion is only seen while the controller waits for it
   assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_W_SETS || state_ff == S_W_BLOCK ||
                           state_ff == S_W_SET))
      else $error("divider finished outside a wait state");
`endif

endmodule
`default_nettype wire

/* sv/two_level_lru_cache_lookup_unit.sv */
// Two-level LRU cache lookup. Each req_ item carries a 1-based byte address;
// each rsp_ item returns its outcome: L1 hit, L2 hit, or miss in both.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. The csr_ port writes l1_entries, ways and bytes per block with
// csr_we; write it only while no item is in flight.
// Work per item: three serial divisions on the shared restoring divider
// (set count, block number, set/tag), a read and a compare state per way
// probed in L1 and L2, a state to restart the scan for L2, a fill state
// per level filled and the control states. The next item can be accepted
// in the cycle after the result is posted. The divider and the single-port
// way scan dominate the time per item; one item is in work at a time.
// The result sits in an output register, so the next item is accepted while
// a finished result waits under rsp_stall; a new result waits in the last
// state until that register empties.
// After reset the block runs a clearing pass over every entry of both tag
// memories and holds req_stall high; configuration writes are taken.
`default_nettype none
module two_level_lru_cache_lookup_unit import tllru_pkg::*; #(
   parameter int MAX_L1_ENTRIES = 256,
   parameter int MAX_WAYS       = 8,
   parameter int ADDR_BITS      = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [ADDR_BITS-1:0]  req_address,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [OUT_W-1:0]           rsp_outcome,
   input  wire logic                  csr_we,
   input  wire logic [CFG_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   tllru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tllru_dpath #(
      .MAX_L1_ENTRIES (MAX_L1_ENTRIES),
      .MAX_WAYS       (MAX_WAYS),
      .ADDR_BITS      (ADDR_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_address (req_address),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_outcome (rsp_outcome)
   );

endmodule
`default_nettype wire
